// ===== hdl/ctb_pkg.sv =====
// Shared types and constants for the countdown timer bank with clock.
package ctb_pkg;

   localparam int unsigned DUR_W      = 24;
   localparam int unsigned TAG_W      = 16;
   localparam int unsigned SLOT_W     = 5;
   localparam int unsigned TPS_W      = 16;
   localparam int unsigned SUB_W      = 16;
   localparam int unsigned SEC_W      = 6;
   localparam int unsigned MIN_W      = 6;
   localparam int unsigned HOUR_W     = 32;
   localparam int unsigned TOTAL_W    = 49;

   localparam logic [TPS_W-1:0] TPS_RESET     = 16'd21;
   localparam logic [SEC_W:0]   SECS_PER_MIN  = 7'd60;
   localparam logic [MIN_W:0]   MINS_PER_HOUR = 7'd60;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef enum logic [1:0] {
      KIND_STARTED = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_EXPIRED = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HOUR_W-1:0]  hours;
      logic [MIN_W-1:0]   minutes;
      logic [SEC_W-1:0]   seconds;
      logic [SUB_W-1:0]   subsecond;
      logic [TOTAL_W-1:0] total_ticks;
   } clock_time_type;

endpackage

// ===== hdl/countdown_timer_bank_with_clock_unit.sv =====
// Top level: countdown slot bank walked by a sequencer, plus the time-of-day clock.
// A tick word is accepted, then each slot is stepped in turn, then the final tick word is emitted.
// A start word scans from slot 0 and loads the first free slot (count zero), ending in a started word, or a full word.
// Throughput: one request word at a time; the single decrement/compare unit visits one
// slot per cycle, and every slot step stalls while the result register holds an untaken word.
// Reset (synchronous, active high) clears all slots, the clock and the result valid flag,
// and sets ticks_per_second to 21; req_ready is high from the first cycle in which reset is low.
module countdown_timer_bank_with_clock_unit #(
   parameter int unsigned SLOTS = 20
) (
   input  logic        clock,
   input  logic        reset,

   // request words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [23:0] req_duration,
   input  logic [15:0] req_callback_tag,
   input  logic        req_has_callback,

   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [4:0]  rsp_slot,
   output logic [15:0] rsp_expired_tag,
   output logic [31:0] rsp_hours,
   output logic [5:0]  rsp_minutes,
   output logic [5:0]  rsp_seconds,
   output logic [15:0] rsp_subsecond,
   output logic [48:0] rsp_total_ticks,
   output logic        rsp_last,

   // ticks_per_second register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_ticks_per_second
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // configuration register, always writable
   logic [ctb_pkg::TPS_W-1:0] tps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= ctb_pkg::TPS_RESET;
      end else if (csr_valid) begin
         tps_ff <= csr_ticks_per_second;
      end
   end

   // slot bank: count, pending flag and tag per slot
   logic [ctb_pkg::DUR_W-1:0] remaining_ff [SLOTS];
   logic                      pending_ff   [SLOTS];
   logic [ctb_pkg::TAG_W-1:0] slot_tag_ff  [SLOTS];

   // latched request word
   logic                      func_ff;
   logic [ctb_pkg::DUR_W-1:0] dur_ff;
   logic [ctb_pkg::TAG_W-1:0] tag_ff;
   logic                      cb_ff;

   ctb_pkg::state_type        state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;

   // sequencer outputs
   logic                      accept;
   logic                      advance;
   logic                      wr_en;
   logic [ctb_pkg::DUR_W-1:0] wr_rem;
   logic                      wr_pend;
   logic                      wr_load;
   logic                      emit;
   ctb_pkg::kind_type         emit_kind;
   logic                      emit_at_slot;
   logic                      emit_last;

   // shared slot unit
   logic [ctb_pkg::DUR_W-1:0] rem_cur;
   logic [ctb_pkg::DUR_W-1:0] rem_dec;
   logic                      out_free;
   logic [31:0]               idx_wide;

   ctb_pkg::clock_time_type   now;

   ctb_clock u_clock (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tps     (tps_ff),
      .now     (now)
   );

   logic rsp_valid_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rem_cur  = remaining_ff[idx_ff];
   assign rem_dec  = (rem_cur != '0) ? (rem_cur - 24'd1) : rem_cur;
   assign idx_wide = 32'(idx_ff);
   assign accept   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctb_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // next state and step control
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_ready    = 1'b0;
      advance      = 1'b0;
      wr_en        = 1'b0;
      wr_rem       = rem_dec;
      wr_pend      = 1'b0;
      wr_load      = 1'b0;
      emit         = 1'b0;
      emit_kind    = ctb_pkg::KIND_TICK;
      emit_at_slot = 1'b0;
      emit_last    = 1'b0;
      unique case (state_ff)
         ctb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // clock moves first so every word of this tick sees the new time
               advance  = (req_func == ctb_pkg::FUNC_TICK);
               idx_in   = '0;
               state_in = ctb_pkg::ST_SCAN;
            end
         end
         ctb_pkg::ST_SCAN: begin
            if (out_free) begin
               if (func_ff == ctb_pkg::FUNC_START) begin
                  if (rem_cur == '0) begin
                     wr_en        = 1'b1;
                     wr_load      = 1'b1;
                     emit         = 1'b1;
                     emit_kind    = ctb_pkg::KIND_STARTED;
                     emit_at_slot = 1'b1;
                     emit_last    = 1'b1;
                     state_in     = ctb_pkg::ST_IDLE;
                  end else if (idx_ff == LAST_IDX) begin
                     state_in = ctb_pkg::ST_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_pend = pending_ff[idx_ff];
                  if (rem_dec == '0 && pending_ff[idx_ff]) begin
                     wr_pend      = 1'b0;
                     emit         = 1'b1;
                     emit_kind    = ctb_pkg::KIND_EXPIRED;
                     emit_at_slot = 1'b1;
                  end
                  if (idx_ff == LAST_IDX) begin
                     state_in = ctb_pkg::ST_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         ctb_pkg::ST_DONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = (func_ff == ctb_pkg::FUNC_START) ? ctb_pkg::KIND_FULL
                                                            : ctb_pkg::KIND_TICK;
               emit_last = 1'b1;
               state_in  = ctb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctb_pkg::ST_IDLE;
         end
      endcase
   end

   // request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         dur_ff  <= req_duration;
         tag_ff  <= req_callback_tag;
         cb_ff   <= req_has_callback;
      end
   end

   // slot bank write, one slot per cycle, held while the result register holds an untaken word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            remaining_ff[i] <= '0;
            pending_ff[i]   <= 1'b0;
            slot_tag_ff[i]  <= '0;
         end
      end else if (wr_en) begin
         if (wr_load) begin
            remaining_ff[idx_ff] <= dur_ff;
            pending_ff[idx_ff]   <= cb_ff;
            slot_tag_ff[idx_ff]  <= tag_ff;
         end else begin
            remaining_ff[idx_ff] <= wr_rem;
            pending_ff[idx_ff]   <= wr_pend;
         end
      end
   end

   // result register; the time is captured with each word
   logic [1:0]                  kind_ff;
   logic [ctb_pkg::SLOT_W-1:0]  slot_ff;
   logic [ctb_pkg::TAG_W-1:0]   etag_ff;
   ctb_pkg::clock_time_type     time_ff;
   logic                        last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= emit_kind;
         slot_ff <= emit_at_slot ? idx_wide[ctb_pkg::SLOT_W-1:0] : '0;
         etag_ff <= (emit_kind == ctb_pkg::KIND_EXPIRED) ? slot_tag_ff[idx_ff] : '0;
         time_ff <= now;
         last_ff <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_expired_tag = etag_ff;
   assign rsp_hours       = time_ff.hours;
   assign rsp_minutes     = time_ff.minutes;
   assign rsp_seconds     = time_ff.seconds;
   assign rsp_subsecond   = time_ff.subsecond;
   assign rsp_total_ticks = time_ff.total_ticks;
   assign rsp_last        = last_ff;

endmodule

// ===== hdl/ctb_clock.sv =====
// Time-of-day counter chain: subsecond, second, minute, hour and total ticks.
module ctb_clock (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [ctb_pkg::TPS_W-1:0]     tps,
   output ctb_pkg::clock_time_type       now
);

   logic [ctb_pkg::SUB_W-1:0]   sub_ff,   sub_in;
   logic [ctb_pkg::SEC_W-1:0]   sec_ff,   sec_in;
   logic [ctb_pkg::MIN_W-1:0]   min_ff,   min_in;
   logic [ctb_pkg::HOUR_W-1:0]  hour_ff,  hour_in;
   logic [ctb_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic [ctb_pkg::SUB_W:0] sub_inc;
   logic [ctb_pkg::SEC_W:0] sec_inc;
   logic [ctb_pkg::MIN_W:0] min_inc;

   always_comb begin
      sub_inc  = {1'b0, sub_ff} + 17'd1;
      sec_inc  = {1'b0, sec_ff} + 7'd1;
      min_inc  = {1'b0, min_ff} + 7'd1;
      sub_in   = sub_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      total_in = total_ff;
      if (advance) begin
         total_in = total_ff + 49'd1;
         // a zero rate rolls over every tick, same as a rate of one
         if (sub_inc >= {1'b0, tps}) begin
            sub_in = '0;
            if (sec_inc >= ctb_pkg::SECS_PER_MIN) begin
               sec_in = '0;
               if (min_inc >= ctb_pkg::MINS_PER_HOUR) begin
                  min_in  = '0;
                  hour_in = hour_ff + 32'd1;
               end else begin
                  min_in = min_inc[ctb_pkg::MIN_W-1:0];
               end
            end else begin
               sec_in = sec_inc[ctb_pkg::SEC_W-1:0];
            end
         end else begin
            sub_in = sub_inc[ctb_pkg::SUB_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         sec_ff   <= '0;
         min_ff   <= '0;
         hour_ff  <= '0;
         total_ff <= '0;
      end else begin
         sub_ff   <= sub_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
         total_ff <= total_in;
      end
   end

   assign now.hours       = hour_ff;
   assign now.minutes     = min_ff;
   assign now.seconds     = sec_ff;
   assign now.subsecond   = sub_ff;
   assign now.total_ticks = total_ff;

endmodule
